// ===== hdl/fcm_pkg.sv =====
// fcm_pkg: constants, command codes, result struct and format layout
// for the file allocation table chain manager
// no dependencies
`default_nettype none

package fcm_pkg;

    localparam int NUM_BLOCKS        = 1024;
    localparam int ENTRIES_PER_BLOCK = 512;
    localparam int BLOCK_W           = $clog2(NUM_BLOCKS);
    localparam int LINK_W            = BLOCK_W + 1;
    localparam int META_BLOCKS       = (NUM_BLOCKS + ENTRIES_PER_BLOCK - 1) / ENTRIES_PER_BLOCK;
    localparam int ROOT_INT          = META_BLOCKS + 1;

    localparam logic [BLOCK_W-1:0] LAST_BLOCK = BLOCK_W'(NUM_BLOCKS - 1);
    localparam logic [BLOCK_W-1:0] ROOT_BLOCK = BLOCK_W'(ROOT_INT);

    // link codes: plain block numbers, end of chain, unused
    localparam logic [LINK_W-1:0] LINK_END  = {{(LINK_W-1){1'b1}}, 1'b0};
    localparam logic [LINK_W-1:0] LINK_FREE = {LINK_W{1'b1}};

    localparam logic [2:0] CMD_FORMAT = 3'd0;
    localparam logic [2:0] CMD_ALLOC  = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] block;
        logic               eoc;
        logic               status;
    } fcm_result_t;

    // table entry written by format at a given index
    function automatic logic [LINK_W-1:0] fmt_entry(logic [BLOCK_W-1:0] idx);
        logic [LINK_W-1:0] v;
        begin
            if (idx == '0)
                v = LINK_END;
            else if (int'(idx) < META_BLOCKS)
                v = LINK_W'(idx) + LINK_W'(1);
            else if (int'(idx) == META_BLOCKS || int'(idx) == META_BLOCKS + 1)
                v = LINK_END;
            else
                v = LINK_FREE;
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fcm_ram.sv =====
// fcm_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module fcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fcm_engine.sv =====
// fcm_engine: command sequencer around the link table ram
// depends on fcm_pkg and fcm_ram
`default_nettype none

module fcm_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [2:0]                  command,
    input  wire logic [fcm_pkg::BLOCK_W-1:0] block,
    input  wire logic                        res_ready,
    output logic                             busy,
    output fcm_pkg::fcm_result_t             res
);

    import fcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_SCAN,
        S_LINK,
        S_ENDW,
        S_WALK,
        S_READ,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [2:0]         cmd_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [BLOCK_W-1:0] cnt_reg;
    logic               issue_reg;
    logic [BLOCK_W-1:0] chk_addr_reg;
    logic               chk_valid_reg;
    logic [BLOCK_W-1:0] found_reg;
    logic [BLOCK_W-1:0] res_block_reg;
    logic               res_eoc_reg;
    logic               res_status_reg;

    logic               fwd_hit_reg;
    logic [LINK_W-1:0]  fwd_data_reg;

    logic               rd_en;
    logic [BLOCK_W-1:0] rd_addr;
    logic               we;
    logic [BLOCK_W-1:0] wr_addr;
    logic [LINK_W-1:0]  wr_data;
    logic [LINK_W-1:0]  ram_rdata;
    logic [LINK_W-1:0]  rdata;

    fcm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // a chain that links to itself reads the entry in the cycle it is freed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= '0;
        end
        else
        begin
            fwd_hit_reg  <= rd_en && we && (rd_addr == wr_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rdata = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = block;
        we      = 1'b0;
        wr_addr = cnt_reg;
        wr_data = LINK_FREE;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (command inside {CMD_FREE, CMD_READ}))
                begin
                    rd_en = 1'b1;
                end
            end
            S_FMT:
            begin
                we      = 1'b1;
                wr_data = fmt_entry(cnt_reg);
            end
            S_SCAN:
            begin
                rd_en   = issue_reg;
                rd_addr = cnt_reg;
            end
            S_LINK:
            begin
                we      = 1'b1;
                wr_addr = blk_reg;
                wr_data = {1'b0, found_reg};
            end
            S_ENDW:
            begin
                we      = 1'b1;
                wr_addr = found_reg;
                wr_data = LINK_END;
            end
            S_WALK:
            begin
                if (rdata != LINK_FREE)
                begin
                    we      = 1'b1;
                    wr_addr = blk_reg;
                    if (rdata != LINK_END)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rdata[BLOCK_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_FORMAT;
            blk_reg        <= '0;
            cnt_reg        <= '0;
            issue_reg      <= 1'b0;
            chk_addr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= '0;
            res_block_reg  <= '0;
            res_eoc_reg    <= 1'b0;
            res_status_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg        <= command;
                        blk_reg        <= block;
                        cnt_reg        <= '0;
                        chk_valid_reg  <= 1'b0;
                        res_block_reg  <= '0;
                        res_eoc_reg    <= 1'b0;
                        res_status_reg <= 1'b0;
                        case (command)
                            CMD_FORMAT: state_reg <= S_FMT;
                            CMD_ALLOC, CMD_APPEND:
                            begin
                                issue_reg <= 1'b1;
                                state_reg <= S_SCAN;
                            end
                            CMD_FREE:   state_reg <= S_WALK;
                            CMD_READ:   state_reg <= S_READ;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_FMT:
                begin
                    cnt_reg <= cnt_reg + BLOCK_W'(1);
                    if (cnt_reg == LAST_BLOCK)
                    begin
                        res_block_reg <= ROOT_BLOCK;
                        state_reg     <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    // read issue runs one address ahead of the check
                    if (issue_reg)
                    begin
                        cnt_reg <= cnt_reg + BLOCK_W'(1);
                        if (cnt_reg == LAST_BLOCK)
                        begin
                            issue_reg <= 1'b0;
                        end
                    end
                    chk_valid_reg <= issue_reg;
                    chk_addr_reg  <= cnt_reg;
                    if (chk_valid_reg && rdata == LINK_FREE)
                    begin
                        issue_reg     <= 1'b0;
                        found_reg     <= chk_addr_reg;
                        res_block_reg <= chk_addr_reg;
                        state_reg     <= (cmd_reg == CMD_APPEND) ? S_LINK : S_ENDW;
                    end
                    else if (chk_valid_reg && chk_addr_reg == LAST_BLOCK)
                    begin
                        res_status_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                end
                S_LINK:
                begin
                    state_reg <= S_ENDW;
                end
                S_ENDW:
                begin
                    state_reg <= S_DONE;
                end
                S_WALK:
                begin
                    // each step frees a used entry, so the walk ends within the table size
                    if (rdata == LINK_FREE || rdata == LINK_END)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        blk_reg <= rdata[BLOCK_W-1:0];
                    end
                end
                S_READ:
                begin
                    if (rdata == LINK_END)
                    begin
                        res_eoc_reg <= 1'b1;
                    end
                    else if (rdata != LINK_FREE)
                    begin
                        res_block_reg <= rdata[BLOCK_W-1:0];
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.block  = res_block_reg;
    assign res.eoc    = res_eoc_reg;
    assign res.status = res_status_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("command started while engine busy");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !we)
        else $error("table written outside a command");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (res.block == '0 && !res.eoc))
        else $error("full-table result carries data");

    a_eoc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.eoc) |-> (res.block == '0 && cmd_reg == CMD_READ))
        else $error("end of chain flagged on a wrong result");

endmodule

`default_nettype wire

// ===== hdl/fat_chain_manager.sv =====
// fat_chain_manager: top level, command channel and registered response
// depends on fcm_pkg and fcm_engine
`default_nettype none

// One command is taken at a time; cmd_stall stays high until the command's
// result has been placed in the response register, and a response waiting
// there does not hold off the next command. Format writes every entry of
// the single link-table ram; allocate and append scan up from index 0 to
// the first free entry, or to the last one when the table is full (append
// also links the given block to the entry found); free walks the chain and
// read looks up one entry. The table holds no defined content until the first
// format; there is no clearing pass after reset.

module fat_chain_manager (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [2:0]                  command,
    input  wire logic [fcm_pkg::BLOCK_W-1:0] block,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic      [fcm_pkg::BLOCK_W-1:0] result_block,
    output logic                             end_of_chain,
    output logic                             status
);

    import fcm_pkg::*;

    logic        busy;
    logic        start;
    logic        res_ready;
    fcm_result_t res;

    logic               rsp_valid_reg;
    logic [BLOCK_W-1:0] result_block_reg;
    logic               end_of_chain_reg;
    logic               status_reg;

    fcm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .block     (block),
        .res_ready (res_ready),
        .busy      (busy),
        .res       (res)
    );

    assign cmd_stall = busy;
    assign start     = cmd_valid && !busy;
    // slot is free when empty or its transfer completes this cycle
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg    <= 1'b0;
            result_block_reg <= '0;
            end_of_chain_reg <= 1'b0;
            status_reg       <= 1'b0;
        end
        else
        begin
            if (res.valid && res_ready)
            begin
                rsp_valid_reg    <= 1'b1;
                result_block_reg <= res.block;
                end_of_chain_reg <= res.eoc;
                status_reg       <= res.status;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_block = result_block_reg;
    assign end_of_chain = end_of_chain_reg;
    assign status       = status_reg;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(result_block) && $stable(status)))
        else $error("stalled response changed");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cmd_stall)
        else $error("second command taken before the first finished");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_ready) |=> rsp_valid)
        else $error("finished result not registered");

endmodule

`default_nettype wire

// ===== tb/fat_chain_manager_test.sv =====
// fat_chain_manager_test: self-checking bench for the allocation table chain manager
// drives commands through a table of directed probes, then random chain traffic and a fill
// to a full table; depends on fcm_pkg and fat_chain_manager
module fat_chain_manager_test;
    import fcm_pkg::*;

    localparam int TABLE_SPAN  = (NUM_BLOCKS + ENTRIES_PER_BLOCK - 1) / ENTRIES_PER_BLOCK;
    localparam int PROBE_ROWS  = 25;
    localparam int ITEM_MIX    = 115;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 1100;

    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic               eoc;
        logic               status;
    } chain_reply_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [BLOCK_W-1:0] blk;
        logic               typed;
        chain_reply_t       want;
    } probe_row_t;

    localparam chain_reply_t ZERO_REPLY = '0;
    localparam chain_reply_t FULL_REPLY = {BLOCK_W'(0), 1'b0, 1'b1};
    localparam chain_reply_t ROOT_REPLY = {BLOCK_W'(TABLE_SPAN + 1), 1'b0, 1'b0};
    localparam chain_reply_t END_REPLY  = {BLOCK_W'(0), 1'b1, 1'b0};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic [2:0]         command   = CMD_FORMAT;
    logic [BLOCK_W-1:0] block     = '0;
    logic               rsp_stall = 1'b0;
    logic               cmd_stall;
    logic               rsp_valid;
    logic [BLOCK_W-1:0] result_block;
    logic               end_of_chain;
    logic               status;

    logic [LINK_W-1:0]  fat_shadow [NUM_BLOCKS];
    chain_reply_t       replies_due [$];
    int                 errors       = 0;
    int                 replies_seen = 0;
    int                 items_sent   = 0;
    int                 burst_left   = 0;

    // 4 is the first unused block after format, 1 links on to 2
    probe_row_t probe_rows [PROBE_ROWS] = '{
        {CMD_FORMAT, LAST_BLOCK,               1'b1, ROOT_REPLY},
        {CMD_READ,   BLOCK_W'(0),              1'b1, END_REPLY},
        {CMD_READ,   BLOCK_W'(1),              1'b1, {BLOCK_W'(2), 1'b0, 1'b0}},
        {CMD_READ,   BLOCK_W'(TABLE_SPAN + 1), 1'b1, END_REPLY},
        {CMD_READ,   BLOCK_W'(4),              1'b1, ZERO_REPLY},
        {CMD_READ,   LAST_BLOCK,               1'b1, ZERO_REPLY},
        {CMD_ALLOC,  BLOCK_W'(10'h2AA),        1'b1, {BLOCK_W'(4), 1'b0, 1'b0}},
        {CMD_APPEND, BLOCK_W'(4),              1'b1, {BLOCK_W'(5), 1'b0, 1'b0}},
        {CMD_APPEND, BLOCK_W'(5),              1'b0, ZERO_REPLY},
        {CMD_READ,   BLOCK_W'(4),              1'b0, ZERO_REPLY},
        {CMD_READ,   BLOCK_W'(6),              1'b0, ZERO_REPLY},
        {CMD_FREE,   BLOCK_W'(4),              1'b1, ZERO_REPLY},
        {CMD_READ,   BLOCK_W'(5),              1'b0, ZERO_REPLY},
        // unused tail: linked to the first-fit block
        {CMD_APPEND, LAST_BLOCK,               1'b0, ZERO_REPLY},
        {CMD_READ,   LAST_BLOCK,               1'b0, ZERO_REPLY},
        // unused tail that first-fit picks itself
        {CMD_APPEND, BLOCK_W'(5),              1'b0, ZERO_REPLY},
        {CMD_READ,   BLOCK_W'(5),              1'b0, ZERO_REPLY},
        {CMD_FREE,   LAST_BLOCK,               1'b1, ZERO_REPLY},
        {CMD_FREE,   BLOCK_W'(900),            1'b1, ZERO_REPLY},
        {CMD_FREE,   BLOCK_W'(0),              1'b1, ZERO_REPLY},
        {CMD_ALLOC,  BLOCK_W'(10'h155),        1'b0, ZERO_REPLY},
        {CMD_RSVD5,  BLOCK_W'(10'h2AA),        1'b1, ZERO_REPLY},
        {CMD_RSVD6,  BLOCK_W'(10'h155),        1'b1, ZERO_REPLY},
        {CMD_RSVD7,  LAST_BLOCK,               1'b1, ZERO_REPLY},
        {CMD_FORMAT, BLOCK_W'(0),              1'b1, ROOT_REPLY}
    };

    fat_chain_manager dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .block        (block),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_block (result_block),
        .end_of_chain (end_of_chain),
        .status       (status)
    );

    always #4 clk = ~clk;

    // updates the shadow table and returns the reply the block owes for this command
    function automatic chain_reply_t apply_fat_command(input logic [2:0] cmd,
                                                       input logic [BLOCK_W-1:0] blk);
        chain_reply_t      reply;
        logic [LINK_W-1:0] link;
        int                idx;
        int                hit;
        int                cur;
        reply = ZERO_REPLY;
        case (cmd)
            CMD_FORMAT:
            begin
                for (idx = 0; idx < NUM_BLOCKS; idx++)
                    if (idx == 0 || idx == TABLE_SPAN || idx == TABLE_SPAN + 1)
                        fat_shadow[idx] = LINK_END;
                    else if (idx < TABLE_SPAN)
                        fat_shadow[idx] = LINK_W'(idx + 1);
                    else
                        fat_shadow[idx] = LINK_FREE;
                reply.block = BLOCK_W'(TABLE_SPAN + 1);
            end
            CMD_ALLOC, CMD_APPEND:
            begin
                hit = -1;
                for (idx = NUM_BLOCKS - 1; idx >= 0; idx--)
                    if (fat_shadow[idx] == LINK_FREE)
                        hit = idx;
                if (hit < 0)
                    reply.status = 1'b1;
                else
                begin
                    if (cmd == CMD_APPEND && int'(blk) < NUM_BLOCKS)
                        fat_shadow[blk] = LINK_W'(hit);
                    fat_shadow[hit] = LINK_END;
                    reply.block = BLOCK_W'(hit);
                end
            end
            CMD_FREE:
            begin
                cur = int'(blk);
                for (idx = 0; idx < NUM_BLOCKS && cur < NUM_BLOCKS; idx++)
                begin
                    link = fat_shadow[cur];
                    if (link == LINK_FREE)
                        break;
                    fat_shadow[cur] = LINK_FREE;
                    if (link == LINK_END)
                        break;
                    cur = int'(link);
                end
            end
            CMD_READ:
            begin
                if (int'(blk) < NUM_BLOCKS)
                begin
                    link = fat_shadow[blk];
                    if (link == LINK_END)
                        reply.eoc = 1'b1;
                    else if (link != LINK_FREE)
                        reply.block = link[BLOCK_W-1:0];
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    // offers one command, waits for its transfer, books the reply, then maybe pauses
    task automatic send_command(input logic [2:0] cmd, input logic [BLOCK_W-1:0] blk,
                                input logic typed, input chain_reply_t want,
                                output chain_reply_t fore);
        cmd_valid <= 1'b1;
        command   <= cmd;
        block     <= blk;
        do
            @(posedge clk);
        while (cmd_stall);
        fore = apply_fat_command(cmd, blk);
        replies_due.push_back(typed ? want : fore);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    initial
    begin : stimulus
        chain_reply_t       fore;
        logic [BLOCK_W-1:0] heads [$];
        logic [BLOCK_W-1:0] tail;
        int                 row;
        int                 pick;
        int                 steps;
        int                 spare;
        int                 lowest;
        int                 seen;
        int                 idx;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PROBE_ROWS; row++)
            send_command(probe_rows[row].cmd, probe_rows[row].blk, probe_rows[row].typed,
                         probe_rows[row].want, fore);

        while (items_sent < ITEM_MIX)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // new chain grown at its tail
                send_command(CMD_ALLOC, BLOCK_W'($urandom), 1'b0, ZERO_REPLY, fore);
                if (!fore.status)
                begin
                    heads.push_back(fore.block);
                    tail = fore.block;
                    repeat ($urandom_range(0, 7))
                    begin
                        send_command(CMD_APPEND, tail, 1'b0, ZERO_REPLY, fore);
                        if (!fore.status)
                            tail = fore.block;
                    end
                end
            end
            else if (pick < 65)
            begin
                tail = (heads.size() != 0 && $urandom_range(0, 3) != 0) ?
                       heads[$urandom_range(0, heads.size() - 1)] : BLOCK_W'($urandom);
                steps = 0;
                do
                begin
                    send_command(CMD_READ, tail, 1'b0, ZERO_REPLY, fore);
                    tail = fore.block;
                    steps++;
                end
                while (!fore.eoc && fore.block != '0 && steps < 12);
            end
            else if (pick < 80)
            begin
                if (heads.size() != 0)
                begin
                    idx  = $urandom_range(0, heads.size() - 1);
                    tail = heads[idx];
                    heads.delete(idx);
                end
                else
                    tail = BLOCK_W'($urandom);
                send_command(CMD_FREE, tail, 1'b0, ZERO_REPLY, fore);
            end
            else if (pick < 98)
                send_command(3'($urandom_range(CMD_ALLOC, CMD_RSVD7)), BLOCK_W'($urandom),
                             1'b0, ZERO_REPLY, fore);
            else
            begin
                send_command(CMD_FORMAT, BLOCK_W'($urandom), 1'b0, ZERO_REPLY, fore);
                heads.delete();
            end
        end

        // append to an unused tail uses up two entries, so the table fills quickly
        forever
        begin
            spare  = 0;
            seen   = 0;
            lowest = -1;
            pick   = -1;
            for (idx = NUM_BLOCKS - 1; idx >= 0; idx--)
                if (fat_shadow[idx] == LINK_FREE)
                begin
                    spare++;
                    lowest = idx;
                end
            if (spare == 0)
                break;
            for (idx = 0; idx < NUM_BLOCKS; idx++)
                if (fat_shadow[idx] == LINK_FREE && idx != lowest)
                begin
                    seen++;
                    if ($urandom_range(1, seen) == 1)
                        pick = idx;
                end
            if ($urandom_range(0, 9) == 0)
                send_command(CMD_READ, BLOCK_W'($urandom), 1'b0, ZERO_REPLY, fore);
            else if (pick >= 0)
                send_command(CMD_APPEND, BLOCK_W'(pick), 1'b0, ZERO_REPLY, fore);
            else
                send_command(CMD_ALLOC, BLOCK_W'($urandom), 1'b0, ZERO_REPLY, fore);
        end

        // full table: refusals, then one chain released and taken up again
        send_command(CMD_ALLOC, BLOCK_W'($urandom), 1'b1, FULL_REPLY, fore);
        send_command(CMD_APPEND, BLOCK_W'($urandom), 1'b1, FULL_REPLY, fore);
        send_command(CMD_READ, BLOCK_W'($urandom), 1'b0, ZERO_REPLY, fore);
        send_command(CMD_FREE, BLOCK_W'($urandom), 1'b1, ZERO_REPLY, fore);
        repeat (6)
            send_command($urandom_range(0, 1) ? CMD_ALLOC : CMD_APPEND, BLOCK_W'($urandom),
                         1'b0, ZERO_REPLY, fore);
        cmd_valid <= 1'b0;

        for (idx = 0; idx < 2000000 && replies_due.size() != 0; idx++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d results never arrived", replies_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : reply_stall
        int mode;
        int phase;
        bit held;
        held  = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && replies_seen >= 30)
            begin
                // long hold-off so the result register fills and commands back up
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 300))
            begin
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 1) == 1);
                    default: rsp_stall <= ((phase % 7) < 3);
                endcase
                phase++;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_replies
        chain_reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            replies_seen++;
            if (replies_due.size() == 0)
            begin
                $error("result transfer with nothing outstanding: block %0d", result_block);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (result_block !== want.block)
                begin
                    $error("result_block: expected %0d, got %0d", want.block, result_block);
                    errors++;
                end
                if (end_of_chain !== want.eoc)
                begin
                    $error("end_of_chain: expected %0b, got %0b", want.eoc, end_of_chain);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
